FILE: design/gapf_pkg.sv
`timescale 1ns / 1ps
package gapf_pkg;

   localparam int ROW_W = 3;
   localparam int COL_W = 4;
   localparam int MASK_W = 16;
   localparam int CSR_W = 4;
   localparam int CSR_IDX_W = 2;
   localparam int HEUR_INT_W = 5;

   localparam int DEF_GRID_ROWS = 7;
   localparam int DEF_GRID_COLS = 16;
   localparam int DEF_HEUR_FRAC_BITS = 16;

   localparam logic [ROW_W-1:0] RST_FROM_ROW = 3'd3;
   localparam logic [COL_W-1:0] RST_FROM_COL = 4'd15;
   localparam logic [ROW_W-1:0] RST_TO_ROW = 3'd3;
   localparam logic [COL_W-1:0] RST_TO_COL = 4'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_FROM_ROW = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FROM_COL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TO_ROW = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TO_COL = 2'd3;

   localparam logic [1:0] DIR_UP = 2'd0;
   localparam logic [1:0] DIR_DOWN = 2'd1;
   localparam logic [1:0] DIR_LEFT = 2'd2;
   localparam logic [1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic op;
      logic [ROW_W-1:0] cell_row;
      logic [COL_W-1:0] cell_col;
   } req_type;

   typedef struct packed {
      logic accepted;
      logic found;
      logic [ROW_W-1:0] row_index;
      logic [MASK_W-1:0] path_mask;
      logic last;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NONE,
      DP_TAKE,
      DP_BLOCK,
      DP_UNBLOCK,
      DP_INIT,
      DP_NB,
      DP_UPD,
      DP_SCAN,
      DP_POP,
      DP_TRACE_INIT,
      DP_TRACE_RD,
      DP_TRACE_STEP,
      DP_EMIT,
      DP_EMIT_REFUSE
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
      logic accepted;
      logic found;
   } dp_cmd_type;

   typedef struct packed {
      logic op_search;
      logic refuse;
      logic start_is_goal;
      logic nb_old;
      logic dir_last;
      logic scan_done;
      logic best_valid;
      logic best_is_goal;
      logic at_origin;
      logic row_last;
      logic rsp_busy;
   } dp_status_type;

   // round-to-nearest integer square root, elaboration use only
   function automatic longint unsigned round_sqrt(input longint unsigned n);
      longint unsigned rem;
      longint unsigned r;
      longint unsigned b;
      rem = n;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return (rem > r) ? r + 1 : r;
   endfunction

   function automatic longint unsigned heur_value(input int dr, input int dc, input int frac);
      return round_sqrt(longint'(dr * dr + dc * dc) << (2 * frac));
   endfunction

endpackage

FILE: design/gapf_ram.sv
`timescale 1ns / 1ps
module gapf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/gapf_datapath.sv
`timescale 1ns / 1ps
module gapf_datapath #(
   parameter int GRID_ROWS = gapf_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = gapf_pkg::DEF_GRID_COLS,
   parameter int HEUR_FRAC_BITS = gapf_pkg::DEF_HEUR_FRAC_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  gapf_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output gapf_pkg::rsp_type                  rsp_data,
   input  logic                               csr_wr_en,
   input  logic [gapf_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gapf_pkg::CSR_W-1:0]         csr_data,
   input  gapf_pkg::dp_cmd_type               cmd,
   output gapf_pkg::dp_status_type            status
);

   localparam int RW = $clog2(GRID_ROWS);
   localparam int CW = $clog2(GRID_COLS);
   localparam int AW = RW + CW;
   localparam int DEPTH = 1 << AW;
   localparam int NCELLS = GRID_ROWS * GRID_COLS;
   localparam int GW = $clog2(NCELLS);
   localparam int OW = AW + 1;
   localparam int HW = gapf_pkg::HEUR_INT_W + HEUR_FRAC_BITS;
   localparam int FIW = (GW > gapf_pkg::HEUR_INT_W ? GW : gapf_pkg::HEUR_INT_W) + 1;
   localparam int FW = FIW + HEUR_FRAC_BITS;
   localparam int CELL_W = GW + FW + 2;
   localparam int SLICE = 1 << CW;

   typedef struct packed {
      logic ok;
      logic [AW-1:0] addr;
   } step_type;

   typedef struct packed {
      logic [GW-1:0] g;
      logic [FW-1:0] f;
      logic [1:0] dir;
   } cell_type;

   function automatic step_type step_cell(input logic [AW-1:0] a, input logic [1:0] d);
      logic [RW-1:0] r;
      logic [CW-1:0] c;
      step_type s;
      r = a[AW-1:CW];
      c = a[CW-1:0];
      s.ok = 1'b0;
      s.addr = a;
      unique case (d)
         gapf_pkg::DIR_UP: begin
            s.ok = (r != '0);
            s.addr = {r - 1'b1, c};
         end
         gapf_pkg::DIR_DOWN: begin
            s.ok = (int'(r) + 1 < GRID_ROWS);
            s.addr = {r + 1'b1, c};
         end
         gapf_pkg::DIR_LEFT: begin
            s.ok = (c != '0);
            s.addr = {r, c - 1'b1};
         end
         gapf_pkg::DIR_RIGHT: begin
            s.ok = (int'(c) + 1 < GRID_COLS);
            s.addr = {r, c + 1'b1};
         end
      endcase
      return s;
   endfunction

   // configuration
   logic [gapf_pkg::ROW_W-1:0] from_row_ff, to_row_ff;
   logic [gapf_pkg::COL_W-1:0] from_col_ff, to_col_ff;
   logic [RW-1:0] sr, gr;
   logic [CW-1:0] sc, gc;
   logic [AW-1:0] sa, ga;

   always_ff @(posedge clock) begin
      if (reset) begin
         from_row_ff <= gapf_pkg::RST_FROM_ROW;
         from_col_ff <= gapf_pkg::RST_FROM_COL;
         to_row_ff <= gapf_pkg::RST_TO_ROW;
         to_col_ff <= gapf_pkg::RST_TO_COL;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            gapf_pkg::CSR_FROM_ROW: from_row_ff <= csr_data[gapf_pkg::ROW_W-1:0];
            gapf_pkg::CSR_FROM_COL: from_col_ff <= csr_data[gapf_pkg::COL_W-1:0];
            gapf_pkg::CSR_TO_ROW: to_row_ff <= csr_data[gapf_pkg::ROW_W-1:0];
            gapf_pkg::CSR_TO_COL: to_col_ff <= csr_data[gapf_pkg::COL_W-1:0];
         endcase
      end
   end

   assign sr = (int'(from_row_ff) >= GRID_ROWS) ? RW'(GRID_ROWS - 1) : RW'(from_row_ff);
   assign sc = (int'(from_col_ff) >= GRID_COLS) ? CW'(GRID_COLS - 1) : CW'(from_col_ff);
   assign gr = (int'(to_row_ff) >= GRID_ROWS) ? RW'(GRID_ROWS - 1) : RW'(to_row_ff);
   assign gc = (int'(to_col_ff) >= GRID_COLS) ? CW'(GRID_COLS - 1) : CW'(to_col_ff);
   assign sa = {sr, sc};
   assign ga = {gr, gc};

   // request
   gapf_pkg::req_type req_ff;
   logic [AW-1:0] ra;
   logic req_off_grid;

   always_ff @(posedge clock) begin
      if (cmd.op == gapf_pkg::DP_TAKE) begin
         req_ff <= req_data;
      end
   end

   assign req_off_grid = (int'(req_ff.cell_row) >= GRID_ROWS) ||
                         (int'(req_ff.cell_col) >= GRID_COLS);
   assign ra = {RW'(req_ff.cell_row), CW'(req_ff.cell_col)};

   // heuristic table
   logic [HW-1:0] htab [GRID_ROWS][GRID_COLS];

   for (genvar gi = 0; gi < GRID_ROWS; gi++) begin : g_hrow
      for (genvar gj = 0; gj < GRID_COLS; gj++) begin : g_hcol
         assign htab[gi][gj] = HW'(gapf_pkg::heur_value(gi, gj, HEUR_FRAC_BITS));
      end
   end

   // search state
   logic [DEPTH-1:0] blocked_ff, open_ff, closed_ff, path_ff;
   logic [AW-1:0] cur_ff;
   logic [GW-1:0] gcur_ff;
   logic [1:0] dir_ff;
   logic [OW-1:0] order_ff;

   step_type nb, par;
   logic [AW-1:0] na;
   logic nb_skip, nb_new, nb_old;
   logic [GW-1:0] g_next;
   logic [RW-1:0] nr, dr;
   logic [CW-1:0] nc, dc;
   logic [FW-1:0] f_new, f_upd;
   logic better;

   cell_type cell_rd, cell_wd;
   logic cell_we;
   logic [AW-1:0] cell_ra;
   logic [AW-1:0] list_q;

   // scan pipeline
   logic scan_run_ff, va_ff, vb_ff, openc_ff, best_v_ff;
   logic [OW-1:0] k_ff;
   logic [AW-1:0] addrc_ff, best_addr_ff;
   logic [FW-1:0] best_f_ff;
   logic [GW-1:0] best_g_ff;

   assign nb = step_cell(cur_ff, dir_ff);
   assign na = nb.addr;
   assign nb_skip = !nb.ok || blocked_ff[na] || closed_ff[na];
   assign nb_new = !nb_skip && !open_ff[na];
   assign nb_old = !nb_skip && open_ff[na];
   assign g_next = gcur_ff + 1'b1;
   assign nr = na[AW-1:CW];
   assign nc = na[CW-1:0];
   assign dr = (nr > gr) ? nr - gr : gr - nr;
   assign dc = (nc > gc) ? nc - gc : gc - nc;
   assign f_new = (FW'(g_next) << HEUR_FRAC_BITS) + FW'(htab[dr][dc]);
   assign better = (g_next < cell_rd.g);
   assign f_upd = cell_rd.f - (FW'(cell_rd.g - g_next) << HEUR_FRAC_BITS);
   assign par = step_cell(cur_ff, cell_rd.dir ^ 2'b01);

   always_comb begin
      cell_we = 1'b0;
      cell_wd = '{g: g_next, f: f_new, dir: dir_ff};
      if (cmd.op == gapf_pkg::DP_NB && nb_new) begin
         cell_we = 1'b1;
      end else if (cmd.op == gapf_pkg::DP_UPD && better) begin
         cell_we = 1'b1;
         cell_wd.f = f_upd;
      end
   end

   always_comb begin
      priority if (va_ff) begin
         cell_ra = list_q;
      end else if (cmd.op == gapf_pkg::DP_TRACE_RD) begin
         cell_ra = cur_ff;
      end else begin
         cell_ra = na;
      end
   end

   gapf_ram #(
      .WIDTH(CELL_W),
      .DEPTH(DEPTH)
   ) u_cell_ram (
      .clock  (clock),
      .wr_en  (cell_we),
      .wr_addr(na),
      .wr_data(cell_wd),
      .rd_addr(cell_ra),
      .rd_data(cell_rd)
   );

   gapf_ram #(
      .WIDTH(AW),
      .DEPTH(DEPTH)
   ) u_list_ram (
      .clock  (clock),
      .wr_en  (cmd.op == gapf_pkg::DP_NB && nb_new),
      .wr_addr(order_ff[AW-1:0]),
      .wr_data(na),
      .rd_addr(k_ff[AW-1:0]),
      .rd_data(list_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         blocked_ff <= '0;
         open_ff <= '0;
         closed_ff <= '0;
         path_ff <= '0;
         order_ff <= '0;
         dir_ff <= gapf_pkg::DIR_UP;
      end else begin
         unique case (cmd.op)
            gapf_pkg::DP_BLOCK: blocked_ff[ra] <= 1'b1;
            gapf_pkg::DP_UNBLOCK: blocked_ff[ra] <= 1'b0;
            gapf_pkg::DP_INIT: begin
               open_ff <= '0;
               closed_ff <= DEPTH'(1) << sa;
               cur_ff <= sa;
               gcur_ff <= '0;
               dir_ff <= gapf_pkg::DIR_UP;
               order_ff <= '0;
            end
            gapf_pkg::DP_NB: begin
               if (nb_new) begin
                  open_ff[na] <= 1'b1;
                  order_ff <= order_ff + 1'b1;
               end
               if (!nb_old) begin
                  dir_ff <= dir_ff + 2'd1;
               end
            end
            gapf_pkg::DP_UPD: dir_ff <= dir_ff + 2'd1;
            gapf_pkg::DP_POP: begin
               open_ff[best_addr_ff] <= 1'b0;
               closed_ff[best_addr_ff] <= 1'b1;
               cur_ff <= best_addr_ff;
               gcur_ff <= best_g_ff;
               dir_ff <= gapf_pkg::DIR_UP;
            end
            gapf_pkg::DP_TRACE_INIT: begin
               path_ff <= '0;
               cur_ff <= ga;
            end
            gapf_pkg::DP_TRACE_STEP: begin
               cur_ff <= par.addr;
               if (par.addr != sa) begin
                  path_ff[par.addr] <= 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   // open-list scan: list read, then cell read, then compare
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_run_ff <= 1'b0;
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         best_v_ff <= 1'b0;
      end else begin
         vb_ff <= va_ff;
         if (cmd.op == gapf_pkg::DP_SCAN) begin
            scan_run_ff <= 1'b1;
            k_ff <= '0;
            va_ff <= 1'b0;
            best_v_ff <= 1'b0;
         end else begin
            va_ff <= scan_run_ff && (k_ff < order_ff);
            if (scan_run_ff) begin
               if (k_ff < order_ff) begin
                  k_ff <= k_ff + 1'b1;
               end else begin
                  scan_run_ff <= 1'b0;
               end
            end
            if (vb_ff && openc_ff && (!best_v_ff || cell_rd.f < best_f_ff)) begin
               best_v_ff <= 1'b1;
               best_addr_ff <= addrc_ff;
               best_f_ff <= cell_rd.f;
               best_g_ff <= cell_rd.g;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      addrc_ff <= list_q;
      openc_ff <= open_ff[list_q];
   end

   // result register
   logic rsp_valid_ff;
   gapf_pkg::rsp_type rsp_data_ff;
   logic [RW-1:0] row_ff;
   logic row_last;
   logic [SLICE-1:0] row_mask;

   assign row_last = (int'(row_ff) == GRID_ROWS - 1);
   assign row_mask = path_ff[{row_ff, {CW{1'b0}}} +: SLICE];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == gapf_pkg::DP_EMIT || cmd.op == gapf_pkg::DP_EMIT_REFUSE) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == gapf_pkg::DP_TRACE_INIT) begin
         row_ff <= '0;
      end else if (cmd.op == gapf_pkg::DP_EMIT) begin
         row_ff <= row_ff + 1'b1;
         rsp_data_ff <= '{accepted: cmd.accepted,
                          found: cmd.found,
                          row_index: gapf_pkg::ROW_W'(row_ff),
                          path_mask: gapf_pkg::MASK_W'(row_mask),
                          last: row_last};
      end else if (cmd.op == gapf_pkg::DP_EMIT_REFUSE) begin
         rsp_data_ff <= '{accepted: 1'b0, found: 1'b0, row_index: '0, path_mask: '0,
                          last: 1'b1};
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   assign status.op_search = req_ff.op;
   assign status.refuse = req_off_grid || blocked_ff[ra] || (ra == sa) || (ra == ga);
   assign status.start_is_goal = (sa == ga);
   assign status.nb_old = nb_old;
   assign status.dir_last = (dir_ff == gapf_pkg::DIR_RIGHT);
   assign status.scan_done = !scan_run_ff && !va_ff && !vb_ff;
   assign status.best_valid = best_v_ff;
   assign status.best_is_goal = (best_addr_ff == ga);
   assign status.at_origin = (cur_ff == sa);
   assign status.row_last = row_last;
   assign status.rsp_busy = rsp_valid_ff && rsp_stall;

endmodule

FILE: design/gapf_ctrl.sv
`timescale 1ns / 1ps
module gapf_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  gapf_pkg::dp_status_type status,
   output gapf_pkg::dp_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REFUSE,
      ST_INIT,
      ST_NB,
      ST_UPD,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_FINISH,
      ST_TRACE_INIT,
      ST_TRACE_CHK,
      ST_TRACE_STEP,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic try_ff, try_in;
   logic found_ff, found_in;
   logic acc_ff, acc_in;
   gapf_pkg::dp_op_type op;

   always_comb begin
      state_in = state_ff;
      try_in = try_ff;
      found_in = found_ff;
      acc_in = acc_ff;
      op = gapf_pkg::DP_NONE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op = gapf_pkg::DP_TAKE;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (status.op_search) begin
               try_in = 1'b0;
               state_in = ST_INIT;
            end else if (status.refuse) begin
               state_in = ST_REFUSE;
            end else begin
               op = gapf_pkg::DP_BLOCK;
               try_in = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_REFUSE: begin
            if (!status.rsp_busy) begin
               op = gapf_pkg::DP_EMIT_REFUSE;
               state_in = ST_IDLE;
            end
         end
         ST_INIT: begin
            op = gapf_pkg::DP_INIT;
            if (status.start_is_goal) begin
               found_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               state_in = ST_NB;
            end
         end
         ST_NB: begin
            op = gapf_pkg::DP_NB;
            priority if (status.nb_old) begin
               state_in = ST_UPD;
            end else if (status.dir_last) begin
               state_in = ST_SCAN;
            end
         end
         ST_UPD: begin
            op = gapf_pkg::DP_UPD;
            state_in = status.dir_last ? ST_SCAN : ST_NB;
         end
         ST_SCAN: begin
            op = gapf_pkg::DP_SCAN;
            state_in = ST_SCAN_WAIT;
         end
         ST_SCAN_WAIT: begin
            if (status.scan_done) begin
               if (!status.best_valid) begin
                  found_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  op = gapf_pkg::DP_POP;
                  if (status.best_is_goal) begin
                     found_in = 1'b1;
                     state_in = ST_FINISH;
                  end else begin
                     state_in = ST_NB;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (try_ff && !found_ff) begin
               op = gapf_pkg::DP_UNBLOCK;
               try_in = 1'b0;
               state_in = ST_INIT;
            end else begin
               acc_in = try_ff;
               state_in = ST_TRACE_INIT;
            end
         end
         ST_TRACE_INIT: begin
            op = gapf_pkg::DP_TRACE_INIT;
            state_in = found_ff ? ST_TRACE_CHK : ST_EMIT;
         end
         ST_TRACE_CHK: begin
            if (status.at_origin) begin
               state_in = ST_EMIT;
            end else begin
               op = gapf_pkg::DP_TRACE_RD;
               state_in = ST_TRACE_STEP;
            end
         end
         ST_TRACE_STEP: begin
            op = gapf_pkg::DP_TRACE_STEP;
            state_in = ST_TRACE_CHK;
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               op = gapf_pkg::DP_EMIT;
               if (status.row_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         try_ff <= 1'b0;
         found_ff <= 1'b0;
         acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         try_ff <= try_in;
         found_ff <= found_in;
         acc_ff <= acc_in;
      end
   end

   assign cmd.op = op;
   assign cmd.accepted = acc_ff;
   assign cmd.found = found_ff;
   assign req_stall = (state_ff != ST_IDLE);

endmodule

FILE: design/grid_astar_path_finder_unit.sv
`timescale 1ns / 1ps
// A* path finder over a 4-connected grid with a blocked-cell map.
// Request channel (req_valid/req_stall/req_data): op 0 blocks a cell and
// searches, undoing the block if it cuts every path; op 1 only searches.
// Response channel (rsp_valid/rsp_stall/rsp_data): one response per grid
// row with the path mask, last set on the final one; a refused block
// request gives a single response. csr_* sets the search endpoints; write
// only while no request is in flight.
// One request at a time: req_stall is high from acceptance until the last
// response is loaded into the output register. A search expands one cell
// at a time, each expansion followed by an open-list scan over the cells
// opened so far, the scan reading the open list and the cell memory one
// entry per cycle. A block that is undone costs two searches, and a found
// path is traced back step by step before the rows are output.
// Reset clears the blocked map and endpoints to their defaults.
// A stalled response holds the output register; the search state machine
// waits on it.
module grid_astar_path_finder_unit #(
   parameter int GRID_ROWS = gapf_pkg::DEF_GRID_ROWS,
   parameter int GRID_COLS = gapf_pkg::DEF_GRID_COLS,
   parameter int HEUR_FRAC_BITS = gapf_pkg::DEF_HEUR_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  gapf_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output gapf_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [gapf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gapf_pkg::CSR_W-1:0]     csr_data
);

   gapf_pkg::dp_cmd_type cmd;
   gapf_pkg::dp_status_type status;

   gapf_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .status   (status),
      .cmd      (cmd)
   );

   gapf_datapath #(
      .GRID_ROWS     (GRID_ROWS),
      .GRID_COLS     (GRID_COLS),
      .HEUR_FRAC_BITS(HEUR_FRAC_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_data (csr_data),
      .cmd      (cmd),
      .status   (status)
   );

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request taken while another is in flight");

   a_no_path_empty_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.found) |-> (rsp_data.path_mask == '0))
      else $error("path mask set without a found path");

   a_keep_needs_path: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_data.accepted || rsp_data.found))
      else $error("block kept without a path");

endmodule
